// File: rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, widths and helpers of the bitmap free allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int CMD_W            = 2;
   localparam int IDX_W            = 12;
   localparam int WORD_W           = 32;
   localparam int BITPOS_W         = 5;
   localparam int WIDE_IDX_W       = 17;
   localparam int MAP_BITS_DEFAULT = 4096;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_TEST  = 2'd2,
      CMD_FIND  = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             bit_value;
      logic             found;
      logic [IDX_W-1:0] free_index;
      logic             bad_index;
   } result_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } ctrl_status_type;

   // Position of the lowest set bit; zero for an all-zero word.
   function automatic logic [BITPOS_W-1:0] lowest_set(input logic [WORD_W-1:0] word);
      logic [BITPOS_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            pos = BITPOS_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// File: rtl/bfa_req_if.sv
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel: command and bit index with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfa_req_if
   import bfa_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [IDX_W-1:0] bit_index;

   modport source (output valid, output command, output bit_index, input ready);
   modport sink   (input valid, input command, input bit_index, output ready);
endinterface

// File: rtl/bfa_rsp_if.sv
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Response channel: one result beat per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfa_rsp_if
   import bfa_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             bit_value;
   logic             found;
   logic [IDX_W-1:0] free_index;
   logic             bad_index;

   modport source (output valid, output bit_value, output found, output free_index,
                   output bad_index, input ready);
   modport sink   (input valid, input bit_value, input found, input free_index,
                   input bad_index, output ready);
endinterface

// File: rtl/bfa_map_ram.sv
// ----------------------------------------------------------------------------
// bfa_map_ram
// Single-clock word memory holding the allocation map, registered read.
// ----------------------------------------------------------------------------
module bfa_map_ram
   import bfa_pkg::*;
#(
   parameter int DEPTH  = MAP_BITS_DEFAULT / WORD_W,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: clearing pass, read-modify-write of one word, and the word scan.
// ----------------------------------------------------------------------------
module bfa_ctrl
   import bfa_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEFAULT,
   parameter int WORDS    = (MAP_BITS + WORD_W - 1) / WORD_W,
   parameter int ADDR_W   = 7
) (
   input  logic              clock,
   input  logic              reset,
   bfa_req_if.sink           req_bus,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [WORD_W-1:0] mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [WORD_W-1:0] mem_rd_data,
   output logic              res_valid,
   input  logic              res_ready,
   output result_type        res,
   output ctrl_status_type   status
);

   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);
   localparam int                RAGGED    = MAP_BITS % WORD_W;
   localparam logic [WORD_W-1:0] LAST_MASK =
      (RAGGED == 0) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << RAGGED) - 64'd1);

   state_type           state_ff, state_in;
   command_type         cmd_ff, cmd_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [ADDR_W-1:0]   ptr_ff, ptr_in;
   result_type          res_ff, res_in;

   logic [WIDE_IDX_W-1:0]      req_idx_wide;
   logic [WIDE_IDX_W-1:0]      cur_idx_wide;
   logic [ADDR_W-1:0]          req_word;
   logic [ADDR_W-1:0]          cur_word;
   logic [WORD_W-1:0]          bit_mask;
   logic [WORD_W-1:0]          zeros;
   logic [ADDR_W+BITPOS_W-1:0] hit_pos;
   logic [WIDE_IDX_W-1:0]      hit_wide;

   assign req_idx_wide = WIDE_IDX_W'(req_bus.bit_index);
   assign cur_idx_wide = WIDE_IDX_W'(idx_ff);
   assign req_word     = req_idx_wide[ADDR_W+BITPOS_W-1:BITPOS_W];
   assign cur_word     = cur_idx_wide[ADDR_W+BITPOS_W-1:BITPOS_W];
   assign bit_mask     = WORD_W'(1) << idx_ff[BITPOS_W-1:0];

   // Bits above the end of the map in a ragged last word never count as free.
   assign zeros    = ~mem_rd_data & ((ptr_ff == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}});
   assign hit_pos  = {ptr_ff, lowest_set(zeros)};
   assign hit_wide = WIDE_IDX_W'(hit_pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      ptr_in      = ptr_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff;
      req_bus.ready = 1'b0;
      res_valid   = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            if (ptr_ff == LAST_WORD) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               cmd_in = command_type'(req_bus.command);
               idx_in = req_bus.bit_index;
               res_in = '0;
               if (command_type'(req_bus.command) == CMD_FIND) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  ptr_in      = '0;
                  state_in    = ST_SCAN;
               end else if (req_idx_wide >= WIDE_IDX_W'(MAP_BITS)) begin
                  res_in.bad_index = 1'b1;
                  state_in         = ST_DONE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = req_word;
                  state_in    = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            // The word read at acceptance is here now; write it back modified.
            mem_wr_addr = cur_word;
            case (cmd_ff)
               CMD_SET: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = mem_rd_data | bit_mask;
               end
               CMD_CLEAR: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = mem_rd_data & ~bit_mask;
               end
               CMD_TEST: begin
                  res_in.bit_value = mem_rd_data[idx_ff[BITPOS_W-1:0]];
               end
               default: begin
               end
            endcase
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (zeros != '0) begin
               res_in.found      = 1'b1;
               res_in.free_index = hit_wide[IDX_W-1:0];
               state_in          = ST_DONE;
            end else if (ptr_ff == LAST_WORD) begin
               state_in = ST_DONE;
            end else begin
               ptr_in      = ptr_ff + 1'b1;
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff + 1'b1;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res             = res_ff;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.idle     = (state_ff == ST_IDLE);

endmodule

// File: rtl/bitmap_free_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_free_allocator
// Allocation bitmap with set, clear, test and find-lowest-free commands.
//
//   Channel   Direction  Beat contents
//   req_bus   in         command, bit_index
//   rsp_bus   out        bit_value, found, free_index, bad_index
//
// Set, clear and test go from acceptance to the result register through
// a memory read, a write-back and a hand-over.
// Find reads one 32-bit word per cycle from word 0 upwards through the
// single read port of the map memory.
// After reset the map is zeroed by a clearing pass, during which no
// request is accepted.
// One request is processed at a time; a finished result waits in the output
// register, so a stalled response only holds the sequencer once a second
// result is ready.
// ----------------------------------------------------------------------------
module bitmap_free_allocator
   import bfa_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bfa_req_if.sink   req_bus,
   bfa_rsp_if.source rsp_bus
);

   localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_data;
   logic              res_valid;
   logic              res_ready;
   result_type        res;
   ctrl_status_type   status;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   bfa_map_ram #(
      .DEPTH  (MAP_WORDS),
      .ADDR_W (ADDR_W)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bfa_ctrl #(
      .MAP_BITS (MAP_BITS),
      .WORDS    (MAP_WORDS),
      .ADDR_W   (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .status      (status)
   );

   // The output register takes a new result whenever it is empty or draining.
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.bit_value  = rsp_data_ff.bit_value;
   assign rsp_bus.found      = rsp_data_ff.found;
   assign rsp_bus.free_index = rsp_data_ff.free_index;
   assign rsp_bus.bad_index  = rsp_data_ff.bad_index;

`ifndef SYNTH
   // No request may slip in while the map is still being zeroed.
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      status.clearing |-> !req_bus.ready
   ) else $error("request accepted during the clearing pass");

   // An accepted request always moves the sequencer out of idle.
   a_accept_leaves_idle: assert property (
      @(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !status.idle
   ) else $error("sequencer stayed idle after accepting a request");

   // A find result never carries a test value or an index error.
   a_found_is_clean: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.found) |-> (!rsp_bus.bit_value && !rsp_bus.bad_index)
   ) else $error("found result carries other flags");

   // A result offered while the output register is stalled must wait.
   a_result_waits: assert property (
      @(posedge clock) disable iff (reset)
      (res_valid && rsp_valid_ff && !rsp_bus.ready) |=> res_valid
   ) else $error("result dropped while the output was stalled");
`endif

endmodule

// File: tb/bfa_result_checker.sv
// ----------------------------------------------------------------------------
// bfa_result_checker
// Watches both channels of the bitmap free allocator, keeps its own copy of
// the allocation map, predicts each response beat and compares it field by
// field with the beat that the block hands over.
// ----------------------------------------------------------------------------
module bfa_result_checker
   import bfa_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   bfa_req_if   req_bus,
   bfa_rsp_if   rsp_bus,
   output int   mismatch_count,
   output int   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_WORDS   = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      command_type      cmd;
      logic [IDX_W-1:0] idx;
      result_type       res;
   } expected_beat_type;

   logic [WORD_W-1:0] shadow_map [MAP_WORDS];
   expected_beat_type expected_results [$];

   // Only the bits below MAP_BITS of a ragged last word can ever be free.
   function automatic logic [WORD_W-1:0] usable_bits(int word_sel);
      int top;
      top = MAP_BITS - word_sel * WORD_W;
      if (top >= WORD_W) begin
         return '1;
      end
      return (WORD_W'(1) << top) - WORD_W'(1);
   endfunction

   function automatic result_type apply_command(command_type cmd, logic [IDX_W-1:0] idx);
      result_type          res;
      logic [WORD_W-1:0]   free_bits;
      logic [WORD_W-1:0]   bit_mask;
      int                  pos;
      int                  word_sel;
      res = '0;
      if (cmd == CMD_FIND) begin
         for (int w = 0; w < MAP_WORDS; w++) begin
            free_bits = ~shadow_map[w] & usable_bits(w);
            if (!res.found && free_bits != '0) begin
               pos = 0;
               for (int b = WORD_W - 1; b >= 0; b--) begin
                  if (free_bits[b]) begin
                     pos = b;
                  end
               end
               res.found      = 1'b1;
               res.free_index = IDX_W'(w * WORD_W + pos);
            end
         end
      end else if (int'(idx) >= MAP_BITS) begin
         res.bad_index = 1'b1;
      end else begin
         word_sel = int'(idx) / WORD_W;
         bit_mask = WORD_W'(1) << (int'(idx) % WORD_W);
         case (cmd)
            CMD_SET: begin
               shadow_map[word_sel] = shadow_map[word_sel] | bit_mask;
            end
            CMD_CLEAR: begin
               shadow_map[word_sel] = shadow_map[word_sel] & ~bit_mask;
            end
            default: begin
               res.bit_value = (shadow_map[word_sel] & bit_mask) != '0;
            end
         endcase
      end
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t ns  mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      expected_beat_type want;
      if (reset) begin
         for (int w = 0; w < MAP_WORDS; w++) begin
            shadow_map[w] = '0;
         end
         expected_results.delete();
         mismatch_count  = 0;
         pending_results <= 0;
      end else begin
         // A response beat always belongs to an older request, so it is
         // matched before the request of the same edge is queued.
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.bit_value !== want.res.bit_value) begin
                  report_mismatch($sformatf("%s %0d: bit_value %b, expected %b",
                     want.cmd.name(), want.idx, rsp_bus.bit_value, want.res.bit_value));
               end
               if (rsp_bus.found !== want.res.found) begin
                  report_mismatch($sformatf("%s %0d: found %b, expected %b",
                     want.cmd.name(), want.idx, rsp_bus.found, want.res.found));
               end
               if (rsp_bus.free_index !== want.res.free_index) begin
                  report_mismatch($sformatf("%s %0d: free_index %0d, expected %0d",
                     want.cmd.name(), want.idx, rsp_bus.free_index, want.res.free_index));
               end
               if (rsp_bus.bad_index !== want.res.bad_index) begin
                  report_mismatch($sformatf("%s %0d: bad_index %b, expected %b",
                     want.cmd.name(), want.idx, rsp_bus.bad_index, want.res.bad_index));
               end
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            want.cmd = command_type'(req_bus.command);
            want.idx = req_bus.bit_index;
            want.res = apply_command(want.cmd, want.idx);
            expected_results.push_back(want);
         end
         pending_results <= expected_results.size();
      end
   end

endmodule

// File: tb/tb_bitmap_free_allocator.sv
// ----------------------------------------------------------------------------
// tb_bitmap_free_allocator
// Drives the bitmap free allocator with a directed opening, a pass that fills
// the low part of the map, and phases of random commands with random gaps on
// the request side and random stalls on the response side.
// The checker beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module tb_bitmap_free_allocator;
   import bfa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The block is built at its default size, so every bit_index lies inside
   // the map and the top index addresses the last bit of the last word.
   localparam int MAP_SIZE       = MAP_BITS_DEFAULT;
   localparam int MAP_WORDS      = (MAP_SIZE + WORD_W - 1) / WORD_W;
   localparam int TOP_INDEX      = (1 << IDX_W) - 1;
   // Positions set by the fill pass, so that later scans walk past full words.
   localparam int FILL_BITS      = 512;
   // Longest quiet stretch of a correct run: the clearing pass, or a full scan
   // followed by the longest response stall and the longest request gap.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = MAP_WORDS + 64;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_BEATS    = 100;

   logic clock;
   logic reset;
   logic gaps_on;
   logic stalls_on;
   int   mismatch_count;
   int   pending_results;
   int   quiet_cycles;

   bfa_req_if req_bus ();
   bfa_rsp_if rsp_bus ();

   bitmap_free_allocator #(
      .MAP_BITS (MAP_SIZE)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bfa_result_checker #(
      .MAP_BITS (MAP_SIZE)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic command_type pick_command(int mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         0: begin
            // Allocation heavy.
            if (r < 50) return CMD_SET;
            if (r < 60) return CMD_CLEAR;
            if (r < 75) return CMD_TEST;
            return CMD_FIND;
         end
         1: begin
            // Release heavy.
            if (r < 10) return CMD_SET;
            if (r < 55) return CMD_CLEAR;
            if (r < 75) return CMD_TEST;
            return CMD_FIND;
         end
         default: begin
            if (r < 30) return CMD_SET;
            if (r < 50) return CMD_CLEAR;
            if (r < 75) return CMD_TEST;
            return CMD_FIND;
         end
      endcase
   endfunction

   task automatic issue(command_type cmd, int idx);
      int gap;
      @(negedge clock);
      req_bus.valid     = 1'b1;
      req_bus.command   = cmd;
      req_bus.bit_index = IDX_W'(idx);
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      gap = 0;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      do begin
         @(posedge clock);
      end while (pending_results != 0);
   endtask

   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (stalls_on && $urandom_range(0, 3) == 0) begin
               stall_left = pick_gap();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int lo;
      int hi;
      int mix;
      int idx;
      reset             = 1'b1;
      gaps_on           = 1'b0;
      stalls_on         = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.command   = CMD_SET;
      req_bus.bit_index = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opening: empty map, word boundaries and the last position.
      issue(CMD_FIND, 0);
      issue(CMD_TEST, 0);
      issue(CMD_SET, 0);
      issue(CMD_TEST, 0);
      issue(CMD_FIND, TOP_INDEX);
      issue(CMD_SET, 1);
      issue(CMD_SET, 31);
      issue(CMD_SET, 32);
      issue(CMD_FIND, 0);
      issue(CMD_SET, MAP_SIZE - 1);
      issue(CMD_TEST, MAP_SIZE - 1);
      issue(CMD_SET, 63);
      issue(CMD_TEST, 63);
      issue(CMD_CLEAR, TOP_INDEX);
      issue(CMD_SET, TOP_INDEX);
      issue(CMD_TEST, TOP_INDEX);
      issue(CMD_SET, 'h555);
      issue(CMD_SET, 'hAAA);
      issue(CMD_TEST, 'hAAA);
      issue(CMD_CLEAR, 0);
      issue(CMD_FIND, 0);
      issue(CMD_CLEAR, MAP_SIZE - 1);
      issue(CMD_TEST, MAP_SIZE - 1);
      issue(CMD_CLEAR, 'h555);
      wait_drained();

      // Fill the low words; the following scans have to step over all of them.
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      for (int i = 0; i < FILL_BITS; i++) begin
         issue(CMD_SET, i);
      end
      issue(CMD_FIND, 0);
      issue(CMD_TEST, FILL_BITS - 1);
      issue(CMD_CLEAR, FILL_BITS - 1);
      issue(CMD_FIND, 0);
      issue(CMD_SET, FILL_BITS - 1);
      issue(CMD_FIND, 0);
      wait_drained();

      // Random phases. The early ones spread over the whole map; later ones
      // work in windows of varying size.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 5) begin
            lo = 0;
            hi = TOP_INDEX;
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  lo = 0;
                  hi = 63;
               end
               1: begin
                  lo = 0;
                  hi = 511;
               end
               2: begin
                  lo = $urandom_range(0, MAP_WORDS - 8) * WORD_W;
                  hi = lo + 255;
               end
               default: begin
                  lo = MAP_SIZE - 64;
                  hi = TOP_INDEX;
               end
            endcase
         end
         mix       = (phase < 5) ? 2 : $urandom_range(0, 2);
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            idx = ($urandom_range(0, 19) == 0) ? $urandom_range(0, TOP_INDEX)
                                               : $urandom_range(lo, hi);
            issue(pick_command(mix), idx);
         end
         if (phase % 5 == 4) begin
            wait_drained();
         end
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      do begin
         @(posedge clock);
      end while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
